FILE: hw/rtl/dsa_pkg.sv
// Shared types and constants for the decimal scale alignment block.
// Used by dsa_ctrl, dsa_datapath and the top level; depends on nothing.
`default_nettype none

package dsa_pkg;

    localparam int unsigned MANT_W      = 96;
    localparam int unsigned WORD_W      = 32;
    localparam int unsigned SCALE_W     = 5;
    localparam int unsigned DEF_MAX_SCALE = 28;

    // floor(2**35 / 10); quotient estimate is at most two below the true one
    localparam logic [31:0] DIV_RECIP = 32'd3435973836;
    localparam int unsigned DIV_SHIFT = 35;

    localparam logic [3:0] DIGIT_HALF = 4'd5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ALIGN,
        ST_DIVIDE,
        ST_ROUND,
        ST_DONE
    } dsa_state_t;

    typedef struct packed {
        logic load;
        logic mul_step;
        logic div_start;
        logic div_step;
        logic round;
        logic out_load;
    } dsa_cmd_t;

    typedef struct packed {
        logic scales_equal;
        logic mul_ovf;
    } dsa_status_t;

endpackage

`default_nettype wire

FILE: hw/rtl/dsa_ctrl.sv
// Controller state machine for the decimal scale alignment block.
// Depends on dsa_pkg; drives dsa_datapath through command and status structs.
`default_nettype none

module dsa_ctrl (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    input  wire dsa_pkg::dsa_status_t status,
    output dsa_pkg::dsa_cmd_t         cmd
);

    dsa_pkg::dsa_state_t state_reg, state_next;
    logic                out_valid_reg, out_valid_next;
    logic                out_free;

    assign out_free = !out_valid_reg || m_ready;
    assign m_valid  = out_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= dsa_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            dsa_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = dsa_pkg::ST_ALIGN;
                end
            end
            dsa_pkg::ST_ALIGN: begin
                if (status.scales_equal) begin
                    state_next = dsa_pkg::ST_DONE;
                end else if (status.mul_ovf) begin
                    // lower-scale operand is full: divide the other one down
                    cmd.div_start = 1'b1;
                    state_next    = dsa_pkg::ST_DIVIDE;
                end else begin
                    cmd.mul_step = 1'b1;
                end
            end
            dsa_pkg::ST_DIVIDE: begin
                if (status.scales_equal) begin
                    state_next = dsa_pkg::ST_ROUND;
                end else begin
                    cmd.div_step = 1'b1;
                end
            end
            dsa_pkg::ST_ROUND: begin
                cmd.round  = 1'b1;
                state_next = dsa_pkg::ST_DONE;
            end
            dsa_pkg::ST_DONE: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = dsa_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = dsa_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.out_load) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/dsa_datapath.sv
// Datapath for the decimal scale alignment block: operand registers, a shared
// multiply-by-ten unit, a word-serial divide-by-ten unit and the output register.
// Depends on dsa_pkg.
`default_nettype none

module dsa_datapath #(
    parameter int unsigned MAX_SCALE = dsa_pkg::DEF_MAX_SCALE
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire dsa_pkg::dsa_cmd_t              cmd,
    output dsa_pkg::dsa_status_t                status,
    input  wire logic [63:0]                    in_first_low,
    input  wire logic [31:0]                    in_first_high,
    input  wire logic                           in_first_negative,
    input  wire logic [dsa_pkg::SCALE_W-1:0]    in_first_scale,
    input  wire logic [63:0]                    in_second_low,
    input  wire logic [31:0]                    in_second_high,
    input  wire logic                           in_second_negative,
    input  wire logic [dsa_pkg::SCALE_W-1:0]    in_second_scale,
    output logic [63:0]                         out_first_low,
    output logic [31:0]                         out_first_high,
    output logic                                out_first_negative,
    output logic [dsa_pkg::SCALE_W-1:0]         out_first_scale,
    output logic [63:0]                         out_second_low,
    output logic [31:0]                         out_second_high,
    output logic                                out_second_negative,
    output logic [dsa_pkg::SCALE_W-1:0]         out_second_scale,
    output logic                                was_rounded
);

    localparam int unsigned MW = dsa_pkg::MANT_W;
    localparam int unsigned WW = dsa_pkg::WORD_W;
    localparam int unsigned SW = dsa_pkg::SCALE_W;
    localparam logic [SW-1:0] MAX_SCALE_V = SW'(MAX_SCALE);

    // working operands
    logic [MW-1:0] a_mant_reg, a_mant_next;
    logic [MW-1:0] b_mant_reg, b_mant_next;
    logic [SW-1:0] a_scale_reg, a_scale_next;
    logic [SW-1:0] b_scale_reg, b_scale_next;
    logic          a_neg_reg, b_neg_reg;
    logic          lo_is_a_reg;
    logic          rounded_reg;

    // divide state
    logic [1:0]    word_idx_reg, word_idx_next;
    logic [3:0]    rem_reg, rem_next;
    logic [3:0]    last_reg, last_next;
    logic          sticky_reg, sticky_next;

    // output register
    logic [MW-1:0] o_a_mant_reg, o_b_mant_reg;
    logic [SW-1:0] o_a_scale_reg, o_b_scale_reg;
    logic          o_a_neg_reg, o_b_neg_reg, o_rounded_reg;

    logic [SW-1:0] sat_first, sat_second;
    logic [MW-1:0] lo_mant, hi_mant;
    logic [SW-1:0] hi_scale;
    logic [MW+3:0] lo_times_ten;
    logic [WW-1:0] cur_word;
    logic [WW+3:0] div_v;
    logic [WW+35:0] div_prod;
    logic [WW-1:0] q_est;
    logic [WW+3:0] q_est_ten;
    logic [WW+3:0] r_est;
    logic [WW-1:0] q_word;
    logic [3:0]    r_digit;
    logic [MW-1:0] hi_div;
    logic          round_up;
    logic [MW-1:0] hi_rounded;
    logic [MW-1:0] hi_new;
    logic          hi_write;
    logic [SW-1:0] hi_scale_new;

    assign sat_first  = (in_first_scale > MAX_SCALE_V) ? MAX_SCALE_V : in_first_scale;
    assign sat_second = (in_second_scale > MAX_SCALE_V) ? MAX_SCALE_V : in_second_scale;

    assign lo_mant  = lo_is_a_reg ? a_mant_reg : b_mant_reg;
    assign hi_mant  = lo_is_a_reg ? b_mant_reg : a_mant_reg;
    assign hi_scale = lo_is_a_reg ? b_scale_reg : a_scale_reg;

    // x*10 = x*8 + x*2
    assign lo_times_ten = {1'b0, lo_mant, 3'b000} + {3'b000, lo_mant, 1'b0};

    assign status.scales_equal = (a_scale_reg == b_scale_reg);
    assign status.mul_ovf      = |lo_times_ten[MW+3:MW];

    // one 32-bit word of the long division by ten, most significant first
    always_comb begin
        case (word_idx_reg)
            2'd2:    cur_word = hi_mant[3*WW-1:2*WW];
            2'd1:    cur_word = hi_mant[2*WW-1:WW];
            2'd0:    cur_word = hi_mant[WW-1:0];
            default: cur_word = '0;
        endcase
    end

    assign div_v     = {rem_reg, cur_word};
    assign div_prod  = {32'b0, div_v} * {36'b0, dsa_pkg::DIV_RECIP};
    assign q_est     = div_prod[dsa_pkg::DIV_SHIFT+WW-1:dsa_pkg::DIV_SHIFT];
    assign q_est_ten = {1'b0, q_est, 3'b000} + {3'b000, q_est, 1'b0};
    assign r_est     = div_v - q_est_ten;

    // estimate may be short by up to two
    always_comb begin
        if (r_est >= 36'd20) begin
            q_word  = q_est + 32'd2;
            r_digit = 4'(r_est - 36'd20);
        end else if (r_est >= 36'd10) begin
            q_word  = q_est + 32'd1;
            r_digit = 4'(r_est - 36'd10);
        end else begin
            q_word  = q_est;
            r_digit = r_est[3:0];
        end
    end

    always_comb begin
        hi_div = hi_mant;
        case (word_idx_reg)
            2'd2:    hi_div[3*WW-1:2*WW] = q_word;
            2'd1:    hi_div[2*WW-1:WW]   = q_word;
            2'd0:    hi_div[WW-1:0]      = q_word;
            default: hi_div = hi_mant;
        endcase
    end

    assign round_up = (last_reg > dsa_pkg::DIGIT_HALF) ||
                      ((last_reg == dsa_pkg::DIGIT_HALF) && (sticky_reg || hi_mant[0]));
    assign hi_rounded = hi_mant + MW'(round_up);

    always_comb begin
        hi_write     = 1'b0;
        hi_new       = hi_mant;
        hi_scale_new = hi_scale;
        word_idx_next = word_idx_reg;
        rem_next      = rem_reg;
        last_next     = last_reg;
        sticky_next   = sticky_reg;
        if (cmd.div_start) begin
            word_idx_next = 2'd2;
            rem_next      = '0;
            last_next     = '0;
            sticky_next   = 1'b0;
        end else if (cmd.div_step) begin
            hi_write = 1'b1;
            hi_new   = hi_div;
            if (word_idx_reg == 2'd0) begin
                // digit complete: retire the previous dropped digit into sticky
                hi_scale_new  = hi_scale - SW'(1);
                word_idx_next = 2'd2;
                rem_next      = '0;
                last_next     = r_digit;
                sticky_next   = sticky_reg || (last_reg != 4'd0);
            end else begin
                word_idx_next = word_idx_reg - 2'd1;
                rem_next      = r_digit;
            end
        end else if (cmd.round) begin
            hi_write = 1'b1;
            hi_new   = hi_rounded;
        end
    end

    always_comb begin
        a_mant_next  = a_mant_reg;
        b_mant_next  = b_mant_reg;
        a_scale_next = a_scale_reg;
        b_scale_next = b_scale_reg;
        if (cmd.load) begin
            a_mant_next  = {in_first_high, in_first_low};
            b_mant_next  = {in_second_high, in_second_low};
            a_scale_next = sat_first;
            b_scale_next = sat_second;
        end else if (cmd.mul_step) begin
            if (lo_is_a_reg) begin
                a_mant_next  = lo_times_ten[MW-1:0];
                a_scale_next = a_scale_reg + SW'(1);
            end else begin
                b_mant_next  = lo_times_ten[MW-1:0];
                b_scale_next = b_scale_reg + SW'(1);
            end
        end else if (hi_write) begin
            if (lo_is_a_reg) begin
                b_mant_next  = hi_new;
                b_scale_next = hi_scale_new;
            end else begin
                a_mant_next  = hi_new;
                a_scale_next = hi_scale_new;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            word_idx_reg <= 2'd2;
            rem_reg      <= '0;
            last_reg     <= '0;
            sticky_reg   <= 1'b0;
            rounded_reg  <= 1'b0;
        end else begin
            word_idx_reg <= word_idx_next;
            rem_reg      <= rem_next;
            last_reg     <= last_next;
            sticky_reg   <= sticky_next;
            if (cmd.load) begin
                rounded_reg <= 1'b0;
            end else if (cmd.div_start) begin
                rounded_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        a_mant_reg  <= a_mant_next;
        b_mant_reg  <= b_mant_next;
        a_scale_reg <= a_scale_next;
        b_scale_reg <= b_scale_next;
        if (cmd.load) begin
            a_neg_reg   <= in_first_negative;
            b_neg_reg   <= in_second_negative;
            lo_is_a_reg <= (sat_first < sat_second);
        end
        if (cmd.out_load) begin
            o_a_mant_reg  <= a_mant_reg;
            o_b_mant_reg  <= b_mant_reg;
            o_a_scale_reg <= a_scale_reg;
            o_b_scale_reg <= b_scale_reg;
            o_a_neg_reg   <= a_neg_reg;
            o_b_neg_reg   <= b_neg_reg;
            o_rounded_reg <= rounded_reg;
        end
    end

    assign out_first_low       = o_a_mant_reg[2*WW-1:0];
    assign out_first_high      = o_a_mant_reg[MW-1:2*WW];
    assign out_first_negative  = o_a_neg_reg;
    assign out_first_scale     = o_a_scale_reg;
    assign out_second_low      = o_b_mant_reg[2*WW-1:0];
    assign out_second_high     = o_b_mant_reg[MW-1:2*WW];
    assign out_second_negative = o_b_neg_reg;
    assign out_second_scale    = o_b_scale_reg;
    assign was_rounded         = o_rounded_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/decimal_scale_align_round_half_even.sv
// Decimal scale alignment with round-half-to-even.
//
// Input channel (s_valid/s_ready): two sign-magnitude decimals, each a 96-bit
// mantissa split into low 64 and high 32 bits, a sign and a scale. Scales above
// MAX_SCALE are saturated. Output channel (m_valid/m_ready): both operands at a
// common scale, signs unchanged, and m_was_rounded when the larger-scale operand
// was divided down.
//
// The smaller-scale operand is multiplied by ten one step per cycle until the
// scales meet or a product would overflow 96 bits; then the other operand is
// divided by ten in a word-serial long division (one 32-bit word per cycle
// through a reciprocal multiplier), and rounded once. One item is in work at
// a time: s_ready is high only in the idle state, which the controller enters
// in the cycle after the result is loaded.
// The result sits in an output register, so a stalled receiver blocks
// only the hand-off of the next finished result, not its computation.
// Reset clears the controller and the output valid; no result is pending.
// Depends on dsa_pkg, dsa_ctrl, dsa_datapath.
`default_nettype none

module decimal_scale_align_round_half_even #(
    parameter int unsigned MAX_SCALE = dsa_pkg::DEF_MAX_SCALE
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic [63:0]                 s_first_mant_low,
    input  wire logic [31:0]                 s_first_mant_high,
    input  wire logic                        s_first_negative,
    input  wire logic [dsa_pkg::SCALE_W-1:0] s_first_scale,
    input  wire logic [63:0]                 s_second_mant_low,
    input  wire logic [31:0]                 s_second_mant_high,
    input  wire logic                        s_second_negative,
    input  wire logic [dsa_pkg::SCALE_W-1:0] s_second_scale,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic [63:0]                      m_out_first_low,
    output logic [31:0]                      m_out_first_high,
    output logic                             m_out_first_negative,
    output logic [dsa_pkg::SCALE_W-1:0]      m_out_first_scale,
    output logic [63:0]                      m_out_second_low,
    output logic [31:0]                      m_out_second_high,
    output logic                             m_out_second_negative,
    output logic [dsa_pkg::SCALE_W-1:0]      m_out_second_scale,
    output logic                             m_was_rounded
);

    dsa_pkg::dsa_cmd_t    cmd;
    dsa_pkg::dsa_status_t status;

    dsa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    dsa_datapath #(
        .MAX_SCALE (MAX_SCALE)
    ) u_datapath (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cmd                 (cmd),
        .status              (status),
        .in_first_low        (s_first_mant_low),
        .in_first_high       (s_first_mant_high),
        .in_first_negative   (s_first_negative),
        .in_first_scale      (s_first_scale),
        .in_second_low       (s_second_mant_low),
        .in_second_high      (s_second_mant_high),
        .in_second_negative  (s_second_negative),
        .in_second_scale     (s_second_scale),
        .out_first_low       (m_out_first_low),
        .out_first_high      (m_out_first_high),
        .out_first_negative  (m_out_first_negative),
        .out_first_scale     (m_out_first_scale),
        .out_second_low      (m_out_second_low),
        .out_second_high     (m_out_second_high),
        .out_second_negative (m_out_second_negative),
        .out_second_scale    (m_out_second_scale),
        .was_rounded         (m_was_rounded)
    );

endmodule

`default_nettype wire
